### rtl/i2c_master_bit_sequencer_macros.svh
// Assertion macros for the I2C master bit sequencer.
// Clock and reset are the block's own aclk and aresetn.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// Checked property, switched off while reset is asserted.
`define I2CMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property that also holds during reset.
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define I2CMS_ASSERT(lbl, prop, msg)
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/i2cms_pkg.sv
`default_nettype none

package i2cms_pkg;

    // Command codes carried in the operation field.
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_WAIT_ACK = 3'd4;

    // Reset value of the acknowledge poll limit.
    localparam logic [9:0] POLL_LIMIT_RESET = 10'd100;

    // Number of data bits in one byte transfer.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Sequencer phases, one per bus slot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST0   = 5'd1,
        PH_ST1   = 5'd2,
        PH_ST2   = 5'd3,
        PH_SP0   = 5'd4,
        PH_SP1   = 5'd5,
        PH_SP2   = 5'd6,
        PH_WRA   = 5'd7,
        PH_WRB   = 5'd8,
        PH_WRC   = 5'd9,
        PH_RDA   = 5'd10,
        PH_RDB   = 5'd11,
        PH_AK0   = 5'd12,
        PH_AK1   = 5'd13,
        PH_AK2   = 5'd14,
        PH_WRISE = 5'd15,
        PH_WPOLL = 5'd16,
        PH_WEND  = 5'd17
    } phase_t;

    // One timing slot as accepted from the input channel.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // One result; packed so that scl_out sits in bit 0.
    typedef struct packed {
        logic       ack_timeout;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

endpackage

`default_nettype wire

### rtl/i2cms_core.sv
`default_nettype none

`include "i2c_master_bit_sequencer_macros.svh"

module i2cms_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire i2cms_pkg::item_t  item,
    input  wire logic [9:0]        poll_limit,
    output i2cms_pkg::result_t     res
);

    i2cms_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [3:0] bit_count_reg, bit_count_next, bit_eff, bit_inc;
    logic [7:0] shift_reg, shift_next, shift_eff;
    logic [9:0] poll_count_reg, poll_count_next, poll_eff;
    logic       scl_level_reg, scl_level_next;
    logic       sda_level_reg, sda_level_next;
    logic       ack_choice_reg, ack_choice_next, ack_eff;
    logic       timeout_seen_reg, timeout_seen_next, tmo_eff;
    logic [7:0] last_read_reg, last_read_next;
    logic       busy, done, tmo_out, ack_level;

    // Command pickup, then one phase of the bus sequence for this slot.
    always_comb begin
        phase_eff = phase_reg;
        bit_eff   = bit_count_reg;
        shift_eff = shift_reg;
        poll_eff  = poll_count_reg;
        ack_eff   = ack_choice_reg;
        tmo_eff   = timeout_seen_reg;

        if (phase_reg == i2cms_pkg::PH_IDLE && item.cmd_valid) begin
            if (item.operation inside {[i2cms_pkg::OP_START:i2cms_pkg::OP_WAIT_ACK]}) begin
                bit_eff  = '0;
                poll_eff = '0;
                tmo_eff  = 1'b0;
            end
            case (item.operation)
                i2cms_pkg::OP_START: begin
                    phase_eff = i2cms_pkg::PH_ST0;
                end
                i2cms_pkg::OP_STOP: begin
                    phase_eff = i2cms_pkg::PH_SP0;
                end
                i2cms_pkg::OP_WRITE: begin
                    phase_eff = i2cms_pkg::PH_WRA;
                    shift_eff = item.write_byte;
                end
                i2cms_pkg::OP_READ: begin
                    phase_eff = i2cms_pkg::PH_RDA;
                    shift_eff = '0;
                    ack_eff   = item.send_ack;
                end
                i2cms_pkg::OP_WAIT_ACK: begin
                    phase_eff = i2cms_pkg::PH_WRISE;
                end
                default: begin
                    phase_eff = i2cms_pkg::PH_IDLE;
                end
            endcase
        end

        phase_next        = phase_eff;
        bit_count_next    = bit_eff;
        shift_next        = shift_eff;
        poll_count_next   = poll_eff;
        ack_choice_next   = ack_eff;
        timeout_seen_next = tmo_eff;
        last_read_next    = last_read_reg;
        scl_level_next    = scl_level_reg;
        sda_level_next    = sda_level_reg;
        busy              = 1'b1;
        done              = 1'b0;
        tmo_out           = 1'b0;
        bit_inc           = bit_eff + 4'd1;
        ack_level         = ~ack_eff;

        case (phase_eff)
            i2cms_pkg::PH_IDLE: begin
                busy = 1'b0;
            end
            i2cms_pkg::PH_ST0: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                phase_next     = i2cms_pkg::PH_ST1;
            end
            i2cms_pkg::PH_ST1: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b0;
                phase_next     = i2cms_pkg::PH_ST2;
            end
            i2cms_pkg::PH_ST2: begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b0;
                done           = 1'b1;
                phase_next     = i2cms_pkg::PH_IDLE;
            end
            i2cms_pkg::PH_SP0: begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b0;
                phase_next     = i2cms_pkg::PH_SP1;
            end
            i2cms_pkg::PH_SP1: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b0;
                phase_next     = i2cms_pkg::PH_SP2;
            end
            i2cms_pkg::PH_SP2: begin
                scl_level_next    = 1'b1;
                sda_level_next    = 1'b1;
                done              = 1'b1;
                tmo_out           = tmo_eff;
                timeout_seen_next = 1'b0;
                phase_next        = i2cms_pkg::PH_IDLE;
            end
            i2cms_pkg::PH_WRA: begin
                scl_level_next = 1'b0;
                sda_level_next = shift_eff[7];
                phase_next     = i2cms_pkg::PH_WRB;
            end
            i2cms_pkg::PH_WRB: begin
                scl_level_next = 1'b1;
                sda_level_next = shift_eff[7];
                phase_next     = i2cms_pkg::PH_WRC;
            end
            i2cms_pkg::PH_WRC: begin
                scl_level_next = 1'b0;
                sda_level_next = shift_eff[7];
                shift_next     = {shift_eff[6:0], 1'b0};
                if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
                    bit_count_next = '0;
                    done           = 1'b1;
                    phase_next     = i2cms_pkg::PH_IDLE;
                end else begin
                    bit_count_next = bit_inc;
                    phase_next     = i2cms_pkg::PH_WRA;
                end
            end
            i2cms_pkg::PH_RDA: begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b1;
                phase_next     = i2cms_pkg::PH_RDB;
            end
            i2cms_pkg::PH_RDB: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                shift_next     = {shift_eff[6:0], item.sda_in};
                if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
                    bit_count_next = '0;
                    phase_next     = i2cms_pkg::PH_AK0;
                end else begin
                    bit_count_next = bit_inc;
                    phase_next     = i2cms_pkg::PH_RDA;
                end
            end
            i2cms_pkg::PH_AK0: begin
                scl_level_next = 1'b0;
                sda_level_next = ack_level;
                phase_next     = i2cms_pkg::PH_AK1;
            end
            i2cms_pkg::PH_AK1: begin
                scl_level_next = 1'b1;
                sda_level_next = ack_level;
                phase_next     = i2cms_pkg::PH_AK2;
            end
            i2cms_pkg::PH_AK2: begin
                scl_level_next = 1'b0;
                sda_level_next = ack_level;
                done           = 1'b1;
                last_read_next = shift_eff;
                phase_next     = i2cms_pkg::PH_IDLE;
            end
            i2cms_pkg::PH_WRISE: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                phase_next     = i2cms_pkg::PH_WPOLL;
            end
            i2cms_pkg::PH_WPOLL: begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                if (!item.sda_in) begin
                    phase_next = i2cms_pkg::PH_WEND;
                end else if (poll_eff >= poll_limit) begin
                    timeout_seen_next = 1'b1;
                    phase_next        = i2cms_pkg::PH_SP0;
                end else begin
                    poll_count_next = poll_eff + 10'd1;
                end
            end
            i2cms_pkg::PH_WEND: begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b1;
                done           = 1'b1;
                phase_next     = i2cms_pkg::PH_IDLE;
            end
            default: begin
                busy       = 1'b0;
                phase_next = i2cms_pkg::PH_IDLE;
            end
        endcase

        res.scl_out     = scl_level_next;
        res.sda_out     = sda_level_next;
        res.busy_res    = busy;
        res.done_res    = done;
        res.read_data   = last_read_next;
        res.ack_timeout = tmo_out;
    end

    // Sequencer state, advanced once per processed slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= i2cms_pkg::PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg        <= '0;
            poll_count_reg   <= '0;
            scl_level_reg    <= 1'b1;
            sda_level_reg    <= 1'b1;
            ack_choice_reg   <= 1'b0;
            timeout_seen_reg <= 1'b0;
            last_read_reg    <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            poll_count_reg   <= poll_count_next;
            scl_level_reg    <= scl_level_next;
            sda_level_reg    <= sda_level_next;
            ack_choice_reg   <= ack_choice_next;
            timeout_seen_reg <= timeout_seen_next;
            last_read_reg    <= last_read_next;
        end
    end

    // A completed command always returns the sequencer to idle.
    `I2CMS_ASSERT(a_done_to_idle, step_en && res.done_res |=> phase_reg == i2cms_pkg::PH_IDLE, "done without return to idle")
    // A timeout is only ever reported on the final slot of a command.
    `I2CMS_ASSERT(a_timeout_with_done, step_en && res.ack_timeout |-> res.done_res && res.busy_res, "timeout flag outside a completing slot")
    // The bit counter never passes a full byte.
    `I2CMS_ASSERT(a_bit_count_range, bit_count_reg <= i2cms_pkg::BITS_PER_BYTE, "bit counter out of range")

endmodule

`default_nettype wire

### rtl/i2c_master_bit_sequencer.sv
// A slot accepted into the input register is stepped by the sequencer and its result is
// registered into the result buffer head, which drives m_tdata.
// Throughput: one slot per cycle while the result buffer has room; the input register
// feeds the sequencer and a two-entry result buffer, and input stalls once both entries fill.
// Reset (aresetn low, synchronous): sequencer idle with SCL and SDA released, poll limit 100,
// input register and result buffer empty.
`default_nettype none

`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input slot channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] write_byte, [8] send_ack, [9] sda_in, rest zero
    input  wire logic [3:0]  s_tuser,  // [0] cmd_valid, [3:1] operation
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                                       // [11:4] read_data, [12] ack_timeout, rest zero
    // Poll limit register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);

    logic                 in_valid_reg, in_valid_next;
    i2cms_pkg::item_t     in_item_reg, in_item_next;
    logic [9:0]           poll_limit_reg;
    logic                 head_valid_reg, head_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    i2cms_pkg::result_t   head_reg, head_next;
    i2cms_pkg::result_t   skid_reg, skid_next;
    i2cms_pkg::result_t   step_res;
    logic                 s_accept, pop, can_push, advance;

    // Handshake control.
    assign pop       = head_valid_reg && m_tready;
    assign can_push  = !skid_valid_reg || pop;
    assign advance   = in_valid_reg && can_push;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = head_valid_reg;
    assign m_tdata   = {3'b000, head_reg};

    // Input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept) begin
            in_valid_next          = 1'b1;
            in_item_next.cmd_valid  = s_tuser[0];
            in_item_next.operation  = s_tuser[3:1];
            in_item_next.write_byte = s_tdata[7:0];
            in_item_next.send_ack   = s_tdata[8];
            in_item_next.sda_in     = s_tdata[9];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

    // Poll limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= i2cms_pkg::POLL_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            poll_limit_reg <= cfg_data;
        end
    end

    // Sequencer step for the registered slot.
    i2cms_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .res        (step_res)
    );

    // Two-entry result buffer: head drives the port, skid catches a result while head stalls.
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_valid_next = advance;
                skid_next       = step_res;
            end else begin
                head_valid_next = advance;
                head_next       = step_res;
            end
        end else if (advance) begin
            if (!head_valid_reg) begin
                head_valid_next = 1'b1;
                head_next       = step_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = step_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever occupied behind a waiting head entry.
    `I2CMS_ASSERT(a_skid_behind_head, skid_valid_reg |-> head_valid_reg, "skid entry valid with empty head")
    // A result is never pushed into a full buffer unless the head leaves in the same cycle.
    `I2CMS_ASSERT(a_no_overflow, advance && skid_valid_reg |-> pop, "result buffer overflow")
    // An accepted slot is held in the input register on the following cycle.
    `I2CMS_ASSERT(a_accept_loads, s_accept |=> in_valid_reg, "accepted slot not registered")

endmodule

`default_nettype wire
